// File: src/cle_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package cle_pkg;

   localparam logic [1:0] CMD_TYPED  = 2'd0;
   localparam logic [1:0] CMD_READ   = 2'd1;
   localparam logic [1:0] CMD_FLUSH  = 2'd2;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   localparam logic [2:0] KIND_ECHO   = 3'd0;
   localparam logic [2:0] KIND_ERASE  = 3'd1;
   localparam logic [2:0] KIND_SIGNAL = 3'd2;
   localparam logic [2:0] KIND_RDBYTE = 3'd3;
   localparam logic [2:0] KIND_STATUS = 3'd4;

   localparam logic [2:0] REG_MODE  = 3'd0;
   localparam logic [2:0] REG_INTR  = 3'd1;
   localparam logic [2:0] REG_SUSP  = 3'd2;
   localparam logic [2:0] REG_ERASE = 3'd3;
   localparam logic [2:0] REG_KILL  = 3'd4;
   localparam logic [2:0] REG_EOF   = 3'd5;

   localparam logic [7:0] DEF_INTR  = 8'h03;
   localparam logic [7:0] DEF_SUSP  = 8'h1A;
   localparam logic [7:0] DEF_ERASE = 8'h7F;
   localparam logic [7:0] DEF_KILL  = 8'h15;
   localparam logic [7:0] DEF_EOF   = 8'h04;
   localparam logic [5:0] DEF_MODE  = 6'h3F;

   localparam logic [7:0] CH_BS    = 8'h08;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_DEL   = 8'h7F;
   localparam logic [7:0] CH_CARET = 8'h5E;
   localparam logic [7:0] CH_C     = 8'h43;
   localparam logic [7:0] CH_Z     = 8'h5A;
   localparam logic [7:0] CH_SPACE = 8'h20;

   localparam int MAX_RES = 5;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] value;
      logic [8:0] erase_count;
      logic       to_console;
   } res_type;

   typedef struct packed {
      logic [5:0] mode;
      logic [7:0] intr_c;
      logic [7:0] susp_c;
      logic [7:0] erase_c;
      logic [7:0] kill_c;
      logic [7:0] eof_c;
   } cfg_type;

endpackage
`default_nettype wire

// File: src/cle_csr.sv
`timescale 1ns / 1ps
`default_nettype none
module cle_csr
   import cle_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       wr_en,
   input  wire logic [2:0] wr_index,
   input  wire logic [7:0] wr_data,
   output cfg_type         cfg
);

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (wr_index)
            REG_MODE:  cfg_in.mode    = wr_data[5:0];
            REG_INTR:  cfg_in.intr_c  = (wr_data == 8'd0) ? DEF_INTR : wr_data;
            REG_SUSP:  cfg_in.susp_c  = (wr_data == 8'd0) ? DEF_SUSP : wr_data;
            REG_ERASE: cfg_in.erase_c = (wr_data == 8'd0) ? DEF_ERASE : wr_data;
            REG_KILL:  cfg_in.kill_c  = wr_data;
            REG_EOF:   cfg_in.eof_c   = wr_data;
            default:   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{mode: DEF_MODE, intr_c: DEF_INTR, susp_c: DEF_SUSP,
                     erase_c: DEF_ERASE, kill_c: DEF_KILL, eof_c: DEF_EOF};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

// File: src/canonical_line_editor.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel | Direction | Ports        | Contents
// req     | in        | req_t*       | tdata[1:0] command, tdata[9:2] byte_in
// rsp     | out       | rsp_t*       | tdata: kind, value, erase_count, to_console,
//         |           |              | data_ready; tlast marks the final result
// csr     | in        | csr_*        | index 0..5 mode, intr, susp, erase, kill, eof
//
// A request is decoded after it is taken, then each result is offered until the
// result side takes it; a read adds a state for the ready ring lookup, and a line
// commit copies the line byte by byte, each byte being first read from the edit
// store and then pushed into the ring.
// Reset is synchronous and active high; it empties the line and the ring and
// loads the default characters. The request side is not ready until every
// result of the previous request has been taken.
module canonical_line_editor
   import cle_pkg::*;
#(
   parameter int EDIT_DEPTH = 256,
   parameter int RING_DEPTH = 512
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // command[1:0], byte_in[9:2]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,   // kind[2:0], value[10:3], erase_count[19:11],
                                         // to_console[20], data_ready[21]
   output logic             rsp_tlast,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [7:0]  csr_data
);

   localparam int EW = $clog2(EDIT_DEPTH);
   localparam int RW = $clog2(RING_DEPTH);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_DECODE = 6'b000010,
      ST_RDEDIT = 6'b000100,
      ST_PUSH   = 6'b001000,
      ST_READ   = 6'b010000,
      ST_EMIT   = 6'b100000
   } state_type;

   cfg_type cfg;
   assign csr_ready = 1'b1;

   cle_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .cfg      (cfg)
   );

   state_type  state_ff, state_in;
   logic [EW:0] count_ff, count_in;
   logic [RW-1:0] head_ff, head_in, tail_ff, tail_in;
   logic        eof_ff, eof_in;
   logic [7:0]  ch_ff, ch_in;
   logic [1:0]  cmd_ff, cmd_in;
   logic [EW:0] idx_ff, idx_in;
   logic        lf_ff, lf_in;   // push LF after the copy
   res_type     res_ff [MAX_RES];
   res_type     res_in [MAX_RES];
   logic [2:0]  nres_ff, nres_in, oidx_ff, oidx_in;

   // Memories.
   logic [7:0] edit_mem [EDIT_DEPTH];
   logic [7:0] ring_mem [RING_DEPTH];
   logic [7:0] edit_rd_ff, ring_rd_ff;
   logic       edit_we, ring_we;
   logic [EW-1:0] edit_waddr, edit_raddr;
   logic [RW-1:0] ring_raddr;
   logic [7:0] edit_wdata, ring_wdata;

   always_ff @(posedge clock) begin
      if (edit_we) edit_mem[edit_waddr] <= edit_wdata;
      edit_rd_ff <= edit_mem[edit_raddr];
   end

   always_ff @(posedge clock) begin
      if (ring_we) ring_mem[head_ff] <= ring_wdata;
      ring_rd_ff <= ring_mem[ring_raddr];
   end

   function automatic logic [RW-1:0] rnext(input logic [RW-1:0] i);
      rnext = (32'(i) + 1 >= RING_DEPTH) ? '0 : RW'(32'(i) + 1);
   endfunction

   wire ring_full = (rnext(head_ff) == tail_ff);

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_EMIT);
   assign rsp_tlast  = (oidx_ff == nres_ff - 3'd1);
   assign rsp_tdata  = {2'b00, (head_ff != tail_ff) || eof_ff,
                        res_ff[oidx_ff].to_console, res_ff[oidx_ff].erase_count,
                        res_ff[oidx_ff].value, res_ff[oidx_ff].kind};

   assign edit_raddr = idx_in[EW-1:0];
   assign ring_raddr = tail_ff;

   always_comb begin
      logic [7:0] c;
      logic echo, echoe, crlf;
      logic [2:0] n;
      state_in = state_ff;
      count_in = count_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      eof_in   = eof_ff;
      ch_in    = ch_ff;
      cmd_in   = cmd_ff;
      idx_in   = idx_ff;
      lf_in    = lf_ff;
      res_in   = res_ff;
      nres_in  = nres_ff;
      oidx_in  = oidx_ff;
      edit_we = 1'b0; edit_waddr = count_ff[EW-1:0]; edit_wdata = ch_ff;
      ring_we = 1'b0; ring_wdata = ch_ff;
      echo  = cfg.mode[3];
      echoe = cfg.mode[4];
      crlf  = cfg.mode[5];
      c = ch_ff;
      n = 3'd0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd_in = req_tdata[1:0];
               ch_in  = (cfg.mode[0] && req_tdata[9:2] == CH_CR) ? CH_LF : req_tdata[9:2];
               nres_in = 3'd0;
               oidx_in = 3'd0;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            state_in = ST_IDLE;
            case (cmd_ff)
               CMD_READ: state_in = ST_READ;
               CMD_FLUSH: begin
                  head_in = '0; tail_in = '0; count_in = '0; eof_in = 1'b0;
               end
               CMD_TYPED: begin
                  if (cfg.mode[1] && (c == cfg.intr_c || c == cfg.susp_c)) begin
                     count_in = '0;
                     res_in[0] = '{KIND_SIGNAL, (c == cfg.intr_c) ? 8'd0 : 8'd1, 9'd0, 1'b0};
                     n = 3'd1;
                     if (echo) begin
                        res_in[1] = '{KIND_ECHO, CH_CARET, 9'd0, 1'b0};
                        res_in[2] = '{KIND_ECHO, (c == cfg.intr_c) ? CH_C : CH_Z, 9'd0, 1'b0};
                        if (crlf) begin
                           res_in[3] = '{KIND_ECHO, CH_CR, 9'd0, 1'b0};
                           res_in[4] = '{KIND_ECHO, CH_LF, 9'd0, 1'b1};
                           n = 3'd5;
                        end else begin
                           res_in[3] = '{KIND_ECHO, CH_LF, 9'd0, 1'b1};
                           n = 3'd4;
                        end
                     end
                  end else if (cfg.mode[2]) begin
                     if (c == cfg.erase_c || c == CH_BS) begin
                        if (count_ff != '0) begin
                           count_in = count_ff - 1'b1;
                           if (echoe) begin
                              res_in[0] = '{KIND_ERASE, 8'd0, 9'd1, 1'b1};
                              n = 3'd1;
                           end
                        end
                     end else if (c == cfg.kill_c) begin
                        if (count_ff != '0 && echoe) begin
                           res_in[0] = '{KIND_ERASE, 8'd0,
                              (32'(count_ff) > 511) ? 9'd511 : 9'(count_ff), 1'b1};
                           n = 3'd1;
                        end
                        count_in = '0;
                     end else if (c == cfg.eof_c) begin
                        if (count_ff != '0) begin
                           idx_in = '0; lf_in = 1'b0; state_in = ST_RDEDIT;
                        end else eof_in = 1'b1;
                     end else if (c == CH_LF) begin
                        if (echo) begin
                           if (crlf) begin
                              res_in[0] = '{KIND_ECHO, CH_CR, 9'd0, 1'b0};
                              res_in[1] = '{KIND_ECHO, CH_LF, 9'd0, 1'b1};
                              n = 3'd2;
                           end else begin
                              res_in[0] = '{KIND_ECHO, CH_LF, 9'd0, 1'b1};
                              n = 3'd1;
                           end
                        end
                        idx_in = '0; lf_in = 1'b1; state_in = ST_RDEDIT;
                     end else if (c == CH_TAB || (c >= CH_SPACE && c < CH_DEL)) begin
                        if (32'(count_ff) < EDIT_DEPTH) begin
                           edit_we = 1'b1;
                           count_in = count_ff + 1'b1;
                           if (echo) begin
                              res_in[0] = '{KIND_ECHO, c, 9'd0, 1'b1};
                              n = 3'd1;
                           end
                        end
                     end
                  end else if (!ring_full) begin
                     ring_we = 1'b1;
                     head_in = rnext(head_ff);
                     if (echo) begin
                        n = 3'd1;
                        if (c == CH_DEL || c == CH_BS)
                           res_in[0] = '{KIND_ERASE, 8'd0, 9'd1, 1'b1};
                        else if (c == CH_LF && crlf) begin
                           res_in[0] = '{KIND_ECHO, CH_CR, 9'd0, 1'b0};
                           res_in[1] = '{KIND_ECHO, CH_LF, 9'd0, 1'b1};
                           n = 3'd2;
                        end else res_in[0] = '{KIND_ECHO, c, 9'd0, 1'b1};
                     end
                  end
               end
               default: state_in = ST_IDLE;
            endcase
            nres_in = n;
            if (state_in == ST_IDLE && n != 3'd0) state_in = ST_EMIT;
         end
         ST_RDEDIT: begin
            // Edit store read for idx_ff is in flight; push next cycle.
            state_in = ST_PUSH;
         end
         ST_PUSH: begin
            if (idx_ff < count_ff) begin
               if (ring_full) begin
                  count_in = '0; state_in = (nres_ff != 0) ? ST_EMIT : ST_IDLE;
               end else begin
                  ring_we = 1'b1; ring_wdata = edit_rd_ff;
                  head_in = rnext(head_ff);
                  idx_in = idx_ff + 1'b1;
                  state_in = ST_RDEDIT;
               end
            end else begin
               count_in = '0;
               if (lf_ff && !ring_full) begin
                  ring_we = 1'b1; ring_wdata = CH_LF; head_in = rnext(head_ff);
               end
               state_in = (nres_ff != 0) ? ST_EMIT : ST_IDLE;
            end
         end
         ST_READ: begin
            nres_in = 3'd1;
            if (head_ff != tail_ff) begin
               res_in[0] = '{KIND_RDBYTE, ring_rd_ff, 9'd0, 1'b0};
               tail_in = rnext(tail_ff);
            end else if (eof_ff) begin
               eof_in = 1'b0;
               res_in[0] = '{KIND_STATUS, 8'd1, 9'd0, 1'b0};
            end else res_in[0] = '{KIND_STATUS, 8'd0, 9'd0, 1'b0};
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (rsp_tready) begin
               oidx_in = oidx_ff + 3'd1;
               if (rsp_tlast) state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         head_ff  <= '0;
         tail_ff  <= '0;
         eof_ff   <= 1'b0;
         nres_ff  <= 3'd0;
         oidx_ff  <= 3'd0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         eof_ff   <= eof_in;
         nres_ff  <= nres_in;
         oidx_ff  <= oidx_in;
      end
   end

   always_ff @(posedge clock) begin
      ch_ff  <= ch_in;
      cmd_ff <= cmd_in;
      idx_ff <= idx_in;
      lf_ff  <= lf_in;
      res_ff <= res_in;
   end

endmodule
`default_nettype wire
